[rtl/elp_pkg.sv]
// Package for the event latency profiler: table sizes, opcodes, status codes
// and the request and response transaction types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package elp_pkg;

   // Outstanding start records and statistics entries
   localparam int OUTSTANDING_DEPTH = 64;
   localparam int EVENT_IDS         = 512;

   localparam int SLOT_W = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;
   localparam int STAT_W = (EVENT_IDS > 1) ? $clog2(EVENT_IDS) : 1;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [2:0] ST_DONE         = 3'd0;
   localparam logic [2:0] ST_NOT_SELECTED = 3'd1;
   localparam logic [2:0] ST_NO_MATCH     = 3'd2;
   localparam logic [2:0] ST_REPLACED     = 3'd3;
   localparam logic [2:0] ST_DROPPED      = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        selected;
      logic [63:0] thread_key;
      logic [8:0]  event_id;
      logic [63:0] timestamp_ns;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [8:0]  matched_id;
      logic [63:0] latency_ns;
      logic [63:0] call_count;
      logic [63:0] total_latency_ns;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/event_latency_profiler.sv]
// Event latency profiler top level: thread-key CAM, start record memory and
// per-id statistics memory with read-modify-write. Depends on elp_pkg.
//
//   port group | dir | payload  | handshake
//   req_       | in  | req_type | req_valid / req_ready
//   rsp_       | out | rsp_type | rsp_valid / rsp_ready
//
// One transaction accepted per cycle while the response register is not stalled.
// Stage 1 does the parallel thread-key match and reads or writes the start
// record memory, stage 2 subtracts timestamps and reads statistics, stage 3
// adds and writes back with a bypass, then the response register.
// After reset a clearing pass over all EVENT_IDS (512) entries zeroes the statistics
// memory; req_ready stays low meanwhile.
// A stalled response register holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none

module event_latency_profiler
   import elp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // ---------------- control ----------------
   logic              advance;
   logic              clr_busy_ff;
   logic [STAT_W-1:0] clr_idx_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !clr_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- stage 1: match ----------------
   logic    s1_vld_ff;
   req_type s1_req_ff;

   logic                         pend_valid_ff [OUTSTANDING_DEPTH];
   logic [63:0]                  pend_key_ff   [OUTSTANDING_DEPTH];
   logic [63:0]                  ptime_mem     [OUTSTANDING_DEPTH];
   logic [8:0]                   pevent_mem    [OUTSTANDING_DEPTH];
   logic [OUTSTANDING_DEPTH-1:0] match_vec;
   logic [OUTSTANDING_DEPTH-1:0] free_vec;
   logic [SLOT_W-1:0]            match_slot;
   logic [SLOT_W-1:0]            free_slot;
   logic                         match_hit;
   logic                         free_hit;
   logic [SLOT_W-1:0]            slot;
   logic                         s1_start;
   logic                         s1_end;
   logic                         rec_write;
   logic                         rec_free;
   logic [2:0]                   s1_status;
   logic [8:0]                   s1_mid;

   always_comb begin
      match_slot = '0;
      free_slot  = '0;
      for (int i = 0; i < OUTSTANDING_DEPTH; i++) begin
         match_vec[i] = pend_valid_ff[i] && (pend_key_ff[i] == s1_req_ff.thread_key);
         free_vec[i]  = !pend_valid_ff[i];
      end
      // lowest index wins
      for (int i = OUTSTANDING_DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_slot = SLOT_W'(i);
         end
         if (free_vec[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign match_hit = |match_vec;
   assign free_hit  = |free_vec;
   assign s1_start  = s1_vld_ff && (s1_req_ff.opcode == OP_START) && s1_req_ff.selected;
   assign s1_end    = s1_vld_ff && (s1_req_ff.opcode == OP_END) && s1_req_ff.selected;
   assign slot      = match_hit ? match_slot : free_slot;
   assign rec_write = advance && s1_start && (match_hit || free_hit);
   assign rec_free  = advance && s1_end && match_hit;

   always_comb begin
      s1_status = ST_DONE;
      s1_mid    = '0;
      case (s1_req_ff.opcode)
         OP_START: begin
            s1_mid = s1_req_ff.event_id;
            if (!s1_req_ff.selected) begin
               s1_status = ST_NOT_SELECTED;
            end else if (match_hit) begin
               s1_status = ST_REPLACED;
            end else if (!free_hit) begin
               s1_status = ST_DROPPED;
            end
         end
         OP_END: begin
            if (!s1_req_ff.selected) begin
               s1_status = ST_NOT_SELECTED;
               s1_mid    = s1_req_ff.event_id;
            end else if (!match_hit) begin
               s1_status = ST_NO_MATCH;
            end
         end
         OP_READ: begin
            s1_mid = s1_req_ff.event_id;
         end
         default: begin
            s1_status = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OUTSTANDING_DEPTH; i++) begin
            pend_valid_ff[i] <= 1'b0;
         end
      end else if (rec_write) begin
         pend_valid_ff[slot] <= 1'b1;
      end else if (rec_free) begin
         pend_valid_ff[slot] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_write) begin
         pend_key_ff[slot] <= s1_req_ff.thread_key;
      end
   end

   // ---------------- stage 2: latency, statistics read ----------------
   logic        s2_vld_ff;
   logic        s2_end_hit_ff;
   logic        s2_read_ff;
   logic [2:0]  s2_status_ff;
   logic [8:0]  s2_mid_ff;
   logic [63:0] s2_ts_ff;
   logic [63:0] ptime_rd_ff;
   logic [8:0]  pevent_rd_ff;
   logic [8:0]  s2_mid;
   logic [63:0] s2_lat;
   logic        s2_in_range;
   logic [STAT_W-1:0] s2_addr;

   // start record memory: one address per cycle while the pipeline advances, registered read
   always_ff @(posedge clock) begin
      if (advance) begin
         if (rec_write) begin
            ptime_mem[slot]  <= s1_req_ff.timestamp_ns;
            pevent_mem[slot] <= s1_req_ff.event_id;
         end
         ptime_rd_ff  <= ptime_mem[slot];
         pevent_rd_ff <= pevent_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_end_hit_ff <= s1_end && match_hit;
         s2_read_ff    <= s1_req_ff.opcode == OP_READ;
         s2_status_ff  <= s1_status;
         s2_mid_ff     <= s1_mid;
         s2_ts_ff      <= s1_req_ff.timestamp_ns;
      end
   end

   assign s2_mid      = s2_end_hit_ff ? pevent_rd_ff : s2_mid_ff;
   assign s2_lat      = s2_end_hit_ff ? (s2_ts_ff - ptime_rd_ff) : 64'd0;
   assign s2_in_range = 32'(s2_mid) < EVENT_IDS;
   assign s2_addr     = STAT_W'(s2_mid);

   // ---------------- stage 3: update, write back ----------------
   logic        s3_vld_ff;
   logic        s3_upd_ff;
   logic        s3_stat_ff;
   logic [2:0]  s3_status_ff;
   logic [8:0]  s3_mid_ff;
   logic [63:0] s3_lat_ff;
   logic [STAT_W-1:0] s3_addr_ff;
   logic [63:0] cnt_rd_ff;
   logic [63:0] tot_rd_ff;
   logic [63:0] cnt_new;
   logic [63:0] tot_new;
   logic        stat_wr;
   logic        mem_wr;
   logic [STAT_W-1:0] mem_addr;
   logic [63:0] cnt_mem [EVENT_IDS];
   logic [63:0] tot_mem [EVENT_IDS];

   assign cnt_new  = s3_upd_ff ? (cnt_rd_ff + 64'd1) : cnt_rd_ff;
   assign tot_new  = s3_upd_ff ? (tot_rd_ff + s3_lat_ff) : tot_rd_ff;
   assign stat_wr  = advance && s3_vld_ff && s3_upd_ff && s3_stat_ff;
   assign mem_wr   = stat_wr || clr_busy_ff;
   assign mem_addr = clr_busy_ff ? clr_idx_ff : s3_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         cnt_mem[mem_addr] <= clr_busy_ff ? 64'd0 : cnt_new;
         tot_mem[mem_addr] <= clr_busy_ff ? 64'd0 : tot_new;
      end
      if (advance) begin
         // forward the write-back of the item ahead to the same entry
         if (stat_wr && (s3_addr_ff == s2_addr)) begin
            cnt_rd_ff <= cnt_new;
            tot_rd_ff <= tot_new;
         end else begin
            cnt_rd_ff <= cnt_mem[s2_addr];
            tot_rd_ff <= tot_mem[s2_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_upd_ff    <= s2_end_hit_ff;
         s3_stat_ff   <= s2_in_range && (s2_end_hit_ff || s2_read_ff);
         s3_status_ff <= s2_status_ff;
         s3_mid_ff    <= s2_mid;
         s3_lat_ff    <= s2_lat;
         s3_addr_ff   <= s2_addr;
      end
   end

   always_comb begin
      rsp_data_in.status           = s3_status_ff;
      rsp_data_in.matched_id       = s3_mid_ff;
      rsp_data_in.latency_ns       = s3_lat_ff;
      rsp_data_in.call_count       = s3_stat_ff ? cnt_new : 64'd0;
      rsp_data_in.total_latency_ns = s3_stat_ff ? tot_new : 64'd0;
   end

   // ---------------- pipeline valids, input and response registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff    <= req_valid && req_ready;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         rsp_valid_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff   <= req_data;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- statistics clearing pass ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_idx_ff == STAT_W'(EVENT_IDS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_idx_ff <= clr_idx_ff + STAT_W'(1);
      end
   end

   // ---------------- assertions ----------------
   a_clear_no_writeback: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !stat_wr)
      else $error("statistics write-back during clearing pass");

   a_clear_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !(s1_vld_ff || s2_vld_ff || s3_vld_ff || rsp_valid_ff))
      else $error("transaction in flight during clearing pass");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $onehot0(match_vec))
      else $error("thread key held by more than one record");

   a_free_clears: assert property (@(posedge clock) disable iff (reset)
      rec_free |=> !pend_valid_ff[$past(slot)])
      else $error("matched record not freed");

endmodule

`default_nettype wire
